// File: rtl/vpb_pkg.sv
`timescale 1ns / 1ps

package vpb_pkg;

    // default sizes of the buffer storage
    localparam int MAX_VCS_DEF    = 4;
    localparam int FIFO_DEPTH_DEF = 8;
    localparam int NODES_DEF      = 4;
    localparam int SUBNETS_DEF    = 2;
    localparam int TAG_WIDTH_DEF  = 32;

    // item field widths
    localparam int NODE_FIELD_W = 2;
    localparam int VC_FIELD_W   = 2;
    localparam int PAYLOAD_W    = 32;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    // input tdata layout, lowest bit first
    localparam int S_NODE_LSB    = 0;
    localparam int S_SUBNET_LSB  = S_NODE_LSB + NODE_FIELD_W;
    localparam int S_VC_LSB      = S_SUBNET_LSB + 1;
    localparam int S_PAYLOAD_LSB = S_VC_LSB + VC_FIELD_W;
    localparam int S_USED_W      = S_PAYLOAD_LSB + PAYLOAD_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_VC_COUNT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUF_CAPACITY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHADER_COUNT = 2'd2;

    localparam logic [2:0] VC_COUNT_RST     = 3'd4;
    localparam logic [3:0] BUF_CAPACITY_RST = 4'd8;
    localparam logic [2:0] SHADER_COUNT_RST = 3'd2;

    // item kinds
    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

endpackage

// File: rtl/vpb_ram.sv
`timescale 1ns / 1ps

// simple dual-port memory, one write and one registered read per cycle
module vpb_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/vc_packet_buffer_round_robin_pop.sv
`timescale 1ns / 1ps
// Steps: a push passes S_PUSH and S_DONE; a pop passes S_RR, S_SCAN for each channel probed
// (1 to the clamped vc_count), S_DRAIN for each flit removed, then S_DONE; a pop for a node
// out of range or with no channel in use goes from accept straight to S_DONE.
// Flow: one item at a time, accepted only in S_IDLE once the last result is registered;
// the sequencer walks channel state and flits through one-read one-write memories.
// Reset: synchronous, active low; then a clearing pass over every channel entry zeroes
// channel state and round-robin pointers while no item is accepted.
module vc_packet_buffer_round_robin_pop #(
    parameter int MAX_VCS    = vpb_pkg::MAX_VCS_DEF,
    parameter int FIFO_DEPTH = vpb_pkg::FIFO_DEPTH_DEF,
    parameter int NODES      = vpb_pkg::NODES_DEF,
    parameter int SUBNETS    = vpb_pkg::SUBNETS_DEF,
    parameter int TAG_WIDTH  = vpb_pkg::TAG_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [vpb_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [vpb_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [vpb_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // node, subnet, vc, payload, pad
    input  logic                            s_axis_tuser,  // action
    input  logic                            s_axis_tlast,  // tail
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [vpb_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // packet_tag, served_vc, pad
    output logic                            m_axis_tuser   // accepted
);

    localparam int VC_W    = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;
    localparam int VCC_W   = $clog2(MAX_VCS + 1);
    localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int RR_AW   = 1 + NODE_W;
    localparam int FIFO_AW = RR_AW + VC_W;
    localparam int FLIT_AW = FIFO_AW + PTR_W;
    localparam int FLIT_W  = TAG_WIDTH + 1;

    typedef struct packed {
        logic [PTR_W-1:0] rd;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] pkt;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_RR,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [2:0] r_vc_count;
    logic [3:0] r_buf_cap;
    logic [2:0] r_shader_count;

    // clearing pass
    logic               r_clearing;
    logic [FIFO_AW-1:0] r_clr_addr;

    // item under work
    logic                 r_push_ok;
    logic                 r_tail;
    logic                 r_net;
    logic [NODE_W-1:0]    r_node_idx;
    logic [VC_W-1:0]      r_served;
    logic [TAG_WIDTH-1:0] r_payload;
    logic [VCC_W-1:0]     r_turn;
    logic [VCC_W-1:0]     r_probe;
    logic [PTR_W-1:0]     r_rd;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_pkt;
    logic                 r_res_acc;
    logic [TAG_WIDTH-1:0] r_res_tag;
    logic [VC_W-1:0]      r_res_vc;

    // output register
    logic                             r_m_valid;
    logic                             r_m_acc;
    logic [vpb_pkg::PAYLOAD_W-1:0]    r_m_tag;
    logic [vpb_pkg::VC_FIELD_W-1:0]   r_m_vc;

    // memory ports
    logic               w_meta_we;
    logic [FIFO_AW-1:0] w_meta_waddr;
    t_meta              w_meta_wdata;
    logic [FIFO_AW-1:0] w_meta_raddr;
    t_meta              w_meta_q;
    logic [META_W-1:0]  w_meta_q_bits;
    logic               w_rr_we;
    logic [RR_AW-1:0]   w_rr_waddr;
    logic [VC_W-1:0]    w_rr_wdata;
    logic [RR_AW-1:0]   w_rr_raddr;
    logic [VC_W-1:0]    w_rr_q;
    logic               w_flit_we;
    logic [FLIT_AW-1:0] w_flit_waddr;
    logic [FLIT_W-1:0]  w_flit_wdata;
    logic [FLIT_AW-1:0] w_flit_raddr;
    logic [FLIT_W-1:0]  w_flit_q;

    // input fields
    logic [vpb_pkg::NODE_FIELD_W-1:0] w_in_node;
    logic                             w_in_subnet;
    logic [vpb_pkg::VC_FIELD_W-1:0]   w_in_vc;
    logic [vpb_pkg::PAYLOAD_W-1:0]    w_in_payload;
    logic [NODE_W-1:0]                w_in_node_idx;

    logic               w_in_fire;
    logic               w_node_ok;
    logic               w_pop_net;
    logic               w_vc_ok;
    logic               w_net_ok;
    logic [VCC_W-1:0]   w_nvc;
    logic [CNT_W-1:0]   w_cap;
    logic [VCC_W-1:0]   w_turn0;
    logic [VCC_W-1:0]   w_turn_inc;
    logic [VCC_W-1:0]   w_turn_nx;
    logic [PTR_W:0]     w_slot_sum;
    logic [PTR_W-1:0]   w_slot;
    logic [PTR_W-1:0]   w_rd_nx;
    logic [CNT_W-1:0]   w_cnt_nx;
    logic               w_push_go;
    logic               w_hit;
    logic               w_drain_end;
    logic               w_out_free;
    logic [FIFO_AW-1:0] w_cur_fifo;
    logic [FIFO_AW-1:0] w_scan_fifo;

    assign w_in_node     = s_axis_tdata[vpb_pkg::S_NODE_LSB +: vpb_pkg::NODE_FIELD_W];
    assign w_in_subnet   = s_axis_tdata[vpb_pkg::S_SUBNET_LSB];
    assign w_in_vc       = s_axis_tdata[vpb_pkg::S_VC_LSB +: vpb_pkg::VC_FIELD_W];
    assign w_in_payload  = s_axis_tdata[vpb_pkg::S_PAYLOAD_LSB +: vpb_pkg::PAYLOAD_W];
    assign w_in_node_idx = NODE_W'(w_in_node);

    assign s_axis_tready = (r_state == S_IDLE) && !r_clearing;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // effective register values, clamped to the storage sizes
    assign w_nvc = (32'(r_vc_count) > 32'(MAX_VCS)) ? VCC_W'(MAX_VCS) : VCC_W'(r_vc_count);
    assign w_cap = (32'(r_buf_cap) > 32'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH) : CNT_W'(r_buf_cap);

    // request checks at accept
    assign w_node_ok = 32'(w_in_node) < 32'(NODES);
    assign w_pop_net = ({1'b0, w_in_node} < r_shader_count) && (SUBNETS > 1);
    assign w_vc_ok   = 8'(w_in_vc) < 8'(w_nvc);
    assign w_net_ok  = (SUBNETS > 1) || !w_in_subnet;

    // round-robin turn handling
    assign w_turn0    = (VCC_W'(w_rr_q) >= w_nvc) ? '0 : VCC_W'(w_rr_q);
    assign w_turn_inc = r_turn + VCC_W'(1);
    assign w_turn_nx  = (w_turn_inc == w_nvc) ? '0 : w_turn_inc;

    assign w_meta_q    = t_meta'(w_meta_q_bits);
    assign w_cur_fifo  = {r_net, r_node_idx, r_served};
    assign w_scan_fifo = {r_net, r_node_idx, VC_W'(r_turn)};

    // push slot: read pointer plus count, wrapped once
    assign w_slot_sum = {1'b0, w_meta_q.rd} + (PTR_W + 1)'(w_meta_q.cnt);
    assign w_slot     = (w_slot_sum >= (PTR_W + 1)'(FIFO_DEPTH))
                      ? PTR_W'(w_slot_sum - (PTR_W + 1)'(FIFO_DEPTH))
                      : PTR_W'(w_slot_sum);
    assign w_push_go  = r_push_ok && (w_meta_q.cnt < w_cap);

    // drain step
    assign w_hit       = w_meta_q.pkt != '0;
    assign w_rd_nx     = (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
    assign w_cnt_nx    = r_cnt - CNT_W'(1);
    assign w_drain_end = w_flit_q[TAG_WIDTH] || (w_cnt_nx == '0);

    assign w_out_free = !r_m_valid || m_axis_tready;

    // memory addresses and writes
    always_comb begin
        w_meta_we    = 1'b0;
        w_meta_waddr = w_cur_fifo;
        w_meta_wdata = '0;
        w_meta_raddr = {w_in_subnet, w_in_node_idx, VC_W'(w_in_vc)};
        w_rr_we      = 1'b0;
        w_rr_waddr   = {r_net, r_node_idx};
        w_rr_wdata   = VC_W'(r_turn);
        w_rr_raddr   = {w_pop_net, w_in_node_idx};
        w_flit_we    = 1'b0;
        w_flit_waddr = {w_cur_fifo, w_slot};
        w_flit_wdata = {r_tail, r_payload};
        w_flit_raddr = {w_cur_fifo, w_rd_nx};
        case (r_state)
            S_PUSH: begin
                if (w_push_go) begin
                    w_flit_we        = 1'b1;
                    w_meta_we        = 1'b1;
                    w_meta_wdata.rd  = w_meta_q.rd;
                    w_meta_wdata.cnt = w_meta_q.cnt + CNT_W'(1);
                    w_meta_wdata.pkt = w_meta_q.pkt + CNT_W'(r_tail);
                end
            end
            S_RR: begin
                w_meta_raddr = {r_net, r_node_idx, VC_W'(w_turn0)};
            end
            S_SCAN: begin
                w_meta_raddr = {r_net, r_node_idx, VC_W'(w_turn_nx)};
                w_flit_raddr = {w_scan_fifo, w_meta_q.rd};
            end
            S_DRAIN: begin
                if (w_drain_end) begin
                    w_meta_we        = 1'b1;
                    w_meta_wdata.rd  = w_rd_nx;
                    w_meta_wdata.cnt = w_cnt_nx;
                    w_meta_wdata.pkt = r_pkt - CNT_W'(1);
                    w_rr_we          = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // clearing pass after reset
        if (r_clearing) begin
            w_meta_we    = 1'b1;
            w_meta_waddr = r_clr_addr;
            w_meta_wdata = '0;
            w_rr_we      = 1'b1;
            w_rr_waddr   = r_clr_addr[FIFO_AW-1:VC_W];
            w_rr_wdata   = '0;
        end
    end

    // per-channel read pointer, flit count and packet count
    vpb_ram #(
        .DATA_W (META_W),
        .ADDR_W (FIFO_AW)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_meta_we),
        .i_wr_addr (w_meta_waddr),
        .i_wr_data (w_meta_wdata),
        .i_rd_addr (w_meta_raddr),
        .o_rd_data (w_meta_q_bits)
    );

    // per-node round-robin pointers
    vpb_ram #(
        .DATA_W (VC_W),
        .ADDR_W (RR_AW)
    ) u_rr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_rr_we),
        .i_wr_addr (w_rr_waddr),
        .i_wr_data (w_rr_wdata),
        .i_rd_addr (w_rr_raddr),
        .o_rd_data (w_rr_q)
    );

    // flit slots, tail mark above the tag
    vpb_ram #(
        .DATA_W (FLIT_W),
        .ADDR_W (FLIT_AW)
    ) u_flit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_flit_we),
        .i_wr_addr (w_flit_waddr),
        .i_wr_data (w_flit_wdata),
        .i_rd_addr (w_flit_raddr),
        .o_rd_data (w_flit_q)
    );

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_vc_count     <= vpb_pkg::VC_COUNT_RST;
            r_buf_cap      <= vpb_pkg::BUF_CAPACITY_RST;
            r_shader_count <= vpb_pkg::SHADER_COUNT_RST;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    vpb_pkg::CFG_VC_COUNT:     r_vc_count     <= i_cfg_wr_data[2:0];
                    vpb_pkg::CFG_BUF_CAPACITY: r_buf_cap      <= i_cfg_wr_data[3:0];
                    vpb_pkg::CFG_SHADER_COUNT: r_shader_count <= i_cfg_wr_data[2:0];
                    default: begin
                    end
                endcase
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + FIFO_AW'(1);
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end

            // taken result leaves unless a new one loads in the same cycle
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_tail     <= s_axis_tlast;
                        r_payload  <= TAG_WIDTH'(w_in_payload);
                        r_node_idx <= w_in_node_idx;
                        r_served   <= VC_W'(w_in_vc);
                        r_res_acc  <= 1'b0;
                        r_res_tag  <= '0;
                        r_res_vc   <= '0;
                        if (s_axis_tuser == vpb_pkg::ACTION_PUSH) begin
                            r_net     <= w_in_subnet;
                            r_push_ok <= w_node_ok && w_net_ok && w_vc_ok;
                            r_state   <= S_PUSH;
                        end else begin
                            r_net     <= w_pop_net;
                            r_push_ok <= 1'b0;
                            if (!w_node_ok || w_nvc == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RR;
                            end
                        end
                    end
                end
                S_PUSH: begin
                    r_res_acc <= w_push_go;
                    r_state   <= S_DONE;
                end
                S_RR: begin
                    r_turn  <= w_turn0;
                    r_probe <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_turn <= w_turn_nx;
                    if (w_hit) begin
                        r_served <= VC_W'(r_turn);
                        r_rd     <= w_meta_q.rd;
                        r_cnt    <= w_meta_q.cnt;
                        r_pkt    <= w_meta_q.pkt;
                        r_state  <= S_DRAIN;
                    end else if (r_probe + VCC_W'(1) == w_nvc) begin
                        r_state <= S_DONE;
                    end else begin
                        r_probe <= r_probe + VCC_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_res_tag <= w_flit_q[TAG_WIDTH-1:0];
                    r_rd      <= w_rd_nx;
                    r_cnt     <= w_cnt_nx;
                    if (w_drain_end) begin
                        r_res_acc <= 1'b1;
                        r_res_vc  <= r_served;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_acc   <= r_res_acc;
                        r_m_tag   <= vpb_pkg::PAYLOAD_W'(r_res_tag);
                        r_m_vc    <= vpb_pkg::VC_FIELD_W'(r_res_vc);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_acc;
    assign m_axis_tdata  = vpb_pkg::M_TDATA_W'({r_m_vc, r_m_tag});

    // a channel being drained still holds flits and a packet
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_cnt != '0) && (r_pkt != '0))
        else $error("drain on an empty channel");

    // the scan never probes more channels than are in use
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_probe < w_nvc))
        else $error("scan ran past the channel count");

    // no item is taken during the clearing pass
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s_axis_tready)
        else $error("item accepted while clearing");

    // a finished result waits while the output register is still held
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_m_valid && !m_axis_tready |=> (r_state == S_DONE))
        else $error("result overwrote a pending output");

endmodule
